// File: src/best_fit_segment_allocator_macros.svh
// Assertion macros for the segment allocator.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define BFSA_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition holds in the cycle after the trigger.
`define BFSA_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// File: src/bfsa_pkg.sv
// Shared constants, codes and controller state type for the segment allocator.
// No dependencies.
package bfsa_pkg;

	localparam int DEF_MAX_SEGMENTS = 64;
	localparam int DEF_HEADER_BYTES = 24;
	localparam int DEF_INITIAL_POOL = 4096;
	localparam int DEF_POOL_LIMIT   = 65536;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OOM      = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR = 2'd2;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_GET,
		S_POP,
		S_WR1,
		S_WR2,
		S_FIND,
		S_MHEAD,
		S_MLOAD,
		S_MERGE,
		S_DONE
	} fsm_t;

endpackage

// File: src/best_fit_segment_allocator.sv
// Best-fit segment allocator: a linked segment table in one synchronous memory,
// a slot recycling stack in a second memory, and the sequencer around them.
// Depends on bfsa_pkg and best_fit_segment_allocator_macros.svh.
//
// One request is handled at a time. The segment table is walked in address
// order through the single read port of the table memory, one entry per cycle.
// An allocate scans the live segments and decides, then, when it splits a
// segment or appends one at the pool end, fetches a slot and writes back two
// entries, and then posts the result. A free walks the table to find the
// segment, then runs the merge pass and posts the result; a null free goes
// straight to posting its result. After reset the block writes the initial
// segment before it takes an item. The result sits in an output register, so
// the next item can be accepted while the previous result still waits.
`include "best_fit_segment_allocator_macros.svh"

module best_fit_segment_allocator
	import bfsa_pkg::*;
#(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES,
	parameter int INITIAL_POOL = DEF_INITIAL_POOL,
	parameter int POOL_LIMIT   = DEF_POOL_LIMIT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] req_size, [31:16] free_addr
	input  logic [0:0]  s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] addr
	output logic [2:0]  m_tuser    // [1:0] status, [2] grew
);

	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [16:0] H17 = 17'(HEADER_BYTES);
	localparam logic [17:0] H18 = 18'(HEADER_BYTES);
	localparam logic [17:0] H2X = 18'(2 * HEADER_BYTES);
	localparam logic [17:0] LIMIT18 = 18'(POOL_LIMIT);
	localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
	localparam logic [15:0] INIT_SIZE =
		16'((INITIAL_POOL >= HEADER_BYTES) ? (INITIAL_POOL - HEADER_BYTES) : 0);

	typedef struct packed {
		logic [15:0]   start;
		logic [15:0]   size;
		logic          free;
		logic [AW-1:0] link;
	} seg_t;

	seg_t seg_mem [MAX_SEGMENTS];
	logic [AW-1:0] stk_mem [MAX_SEGMENTS];

	fsm_t state_q, state_d;

	seg_t          rd_q, cur_q, best_q, last_q;
	logic [AW-1:0] nxt_q, cur_idx_q, best_idx_q, last_idx_q, new_idx_q, stk_rd_q;
	logic          found_q, grow_q;
	logic [15:0]   req_q, faddr_q;
	logic [CW-1:0] count_q, fresh_q, sp_q, sp_m1;
	logic [16:0]   pool_end_q;
	logic [1:0]    res_status_q;
	logic [15:0]   res_addr_q;
	logic          res_grew_q;

	logic          mem_we, stk_we;
	logic [AW-1:0] mem_wa, mem_ra;
	seg_t          mem_wd, merged;

	logic          accept, fits, split_ok, grow_bad, hit, join_ok, can_post;
	logic [16:0]   need;
	logic [17:0]   need2, new_end, payload;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign can_post = !m_tvalid || m_tready;
	assign sp_m1    = sp_q - 1'b1;

	assign need  = {1'b0, req_q} + H17;
	assign need2 = {2'b0, req_q} + H2X;
	assign fits  = rd_q.free && ({1'b0, rd_q.size} >= need) &&
		(!found_q || (rd_q.size < best_q.size));
	assign split_ok = ({2'b0, best_q.size} >= need2) && (count_q < MAXC);
	assign new_end  = {1'b0, pool_end_q} + H18 + {2'b0, req_q};
	assign payload  = {1'b0, pool_end_q} + H18;
	assign grow_bad = (count_q >= MAXC) || (new_end > LIMIT18) || (payload > 18'hFFFF);
	assign hit      = (({1'b0, rd_q.start} + H17) == {1'b0, faddr_q});
	assign join_ok  = cur_q.free && rd_q.free;

	always_comb begin
		merged      = cur_q;
		merged.size = cur_q.size + rd_q.size + H17[15:0];
		merged.link = rd_q.link;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wa  = nxt_q;
		mem_wd  = rd_q;
		mem_ra  = rd_q.link;
		stk_we  = 1'b0;
		unique case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
				mem_wa = '0;
				mem_wd = '{start: 16'd0, size: INIT_SIZE, free: 1'b1, link: '0};
				state_d = S_IDLE;
			end
			S_IDLE: begin
				mem_ra = '0;
				if (accept) begin
					if (s_tuser[0] == CMD_ALLOC) begin
						state_d = S_SCAN;
					end else if (s_tdata[31:16] == 16'd0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_FIND;
					end
				end
			end
			S_SCAN: begin
				if (rd_q.link == '0) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (found_q) begin
					if (split_ok) begin
						state_d = S_GET;
					end else begin
						mem_we      = 1'b1;
						mem_wa      = best_idx_q;
						mem_wd      = best_q;
						mem_wd.free = 1'b0;
						state_d     = S_DONE;
					end
				end else begin
					state_d = grow_bad ? S_DONE : S_GET;
				end
			end
			S_GET: begin
				state_d = (sp_q != '0) ? S_POP : S_WR1;
			end
			S_POP: begin
				state_d = S_WR1;
			end
			S_WR1: begin
				mem_we = 1'b1;
				mem_wa = new_idx_q;
				if (grow_q) begin
					mem_wd = '{start: pool_end_q[15:0], size: req_q, free: 1'b0, link: '0};
				end else begin
					mem_wd = '{start: best_q.start + req_q + H17[15:0],
						size: best_q.size - req_q - H17[15:0],
						free: 1'b1, link: best_q.link};
				end
				state_d = S_WR2;
			end
			S_WR2: begin
				mem_we = 1'b1;
				if (grow_q) begin
					mem_wa      = last_idx_q;
					mem_wd      = last_q;
					mem_wd.link = new_idx_q;
				end else begin
					mem_wa = best_idx_q;
					mem_wd = '{start: best_q.start, size: req_q, free: 1'b0, link: new_idx_q};
				end
				state_d = S_DONE;
			end
			S_FIND: begin
				if (hit) begin
					mem_we      = 1'b1;
					mem_wa      = nxt_q;
					mem_wd      = rd_q;
					mem_wd.free = 1'b1;
					state_d     = S_MHEAD;
				end else if (rd_q.link == '0) begin
					state_d = S_DONE;
				end
			end
			S_MHEAD: begin
				mem_ra  = '0;
				state_d = S_MLOAD;
			end
			S_MLOAD: begin
				if (rd_q.link == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_MERGE;
				end
			end
			S_MERGE: begin
				if (join_ok) begin
					mem_we = 1'b1;
					mem_wa = cur_idx_q;
					mem_wd = merged;
					stk_we = 1'b1;
				end
				if (rd_q.link == '0) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (can_post) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// table and recycle stack, registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			seg_mem[mem_wa] <= mem_wd;
		end
		rd_q <= seg_mem[mem_ra];
		if (stk_we) begin
			stk_mem[sp_q[AW-1:0]] <= nxt_q;
		end
		stk_rd_q <= stk_mem[sp_m1[AW-1:0]];
	end

	// walk registers and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q        <= s_tdata[15:0];
				faddr_q      <= s_tdata[31:16];
				found_q      <= 1'b0;
				nxt_q        <= '0;
				res_status_q <= ST_OK;
				res_addr_q   <= 16'd0;
				res_grew_q   <= 1'b0;
			end
			S_SCAN: begin
				nxt_q      <= rd_q.link;
				last_q     <= rd_q;
				last_idx_q <= nxt_q;
				if (fits) begin
					best_q     <= rd_q;
					best_idx_q <= nxt_q;
					found_q    <= 1'b1;
				end
			end
			S_DECIDE: begin
				grow_q <= !found_q;
				if (found_q && !split_ok) begin
					res_addr_q <= best_q.start + H17[15:0];
				end
				if (!found_q && grow_bad) begin
					res_status_q <= ST_OOM;
				end
			end
			S_GET: begin
				if (sp_q == '0) begin
					new_idx_q <= fresh_q[AW-1:0];
				end
			end
			S_POP: begin
				new_idx_q <= stk_rd_q;
			end
			S_WR2: begin
				res_addr_q <= grow_q ? payload[15:0] : (best_q.start + H17[15:0]);
				res_grew_q <= grow_q;
			end
			S_FIND: begin
				nxt_q <= rd_q.link;
				if (!hit && (rd_q.link == '0)) begin
					res_status_q <= ST_BAD_ADDR;
				end
			end
			S_MLOAD: begin
				cur_q     <= rd_q;
				cur_idx_q <= '0;
				nxt_q     <= rd_q.link;
			end
			S_MERGE: begin
				nxt_q <= rd_q.link;
				if (join_ok) begin
					cur_q <= merged;
				end else begin
					cur_q     <= rd_q;
					cur_idx_q <= nxt_q;
				end
			end
			S_DONE: begin
				if (can_post) begin
					m_tdata <= res_addr_q;
					m_tuser <= {res_grew_q, res_status_q};
				end
			end
			default: begin
			end
		endcase
	end

	// occupancy bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= CW'(1);
			fresh_q    <= CW'(1);
			sp_q       <= '0;
			pool_end_q <= 17'(INITIAL_POOL);
		end else begin
			if (state_q == S_GET) begin
				count_q <= count_q + 1'b1;
				if (sp_q != '0) begin
					sp_q <= sp_q - 1'b1;
				end else begin
					fresh_q <= fresh_q + 1'b1;
				end
			end
			if (stk_we) begin
				count_q <= count_q - 1'b1;
				sp_q    <= sp_q + 1'b1;
			end
			if ((state_q == S_WR2) && grow_q) begin
				pool_end_q <= new_end[16:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if ((state_q == S_DONE) && can_post) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	`BFSA_ASSERT_NOW(a_slot_books, 1'b1, ({1'b0, sp_q} + {1'b0, count_q}) == {1'b0, fresh_q}, "slot accounting broken")
	`BFSA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != S_IDLE, "item accepted but sequencer idle")
	`BFSA_ASSERT_NEXT(a_done_waits, (state_q == S_DONE) && m_tvalid && !m_tready, state_q == S_DONE, "result dropped while output stalled")

endmodule
